/* rtl/flos_pkg.sv */
package flos_pkg;

  localparam int DEPTH      = 1024;
  localparam int ELEM_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int LW         = AW + 1;
  localparam int PW         = AW + 2;
  localparam int POS_W      = 11;
  localparam int LEN_W      = 11;

  typedef logic [AW-1:0]                addr_t;
  typedef logic [LW-1:0]                len_t;
  typedef logic signed [PW-1:0]         pos_t;
  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic  start;
    len_t  len;
    elem_t key;
  } srch_cmd_t;

  typedef struct packed {
    logic busy;
    pos_t hit;
  } srch_stat_t;

endpackage

/* rtl/flos_store.sv */
module flos_store
  import flos_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  elem_t wr_data,
  input  addr_t rd_addr_a,
  output elem_t rd_data_a,
  input  addr_t rd_addr_b,
  output elem_t rd_data_b
);

  elem_t mem [DEPTH];
  elem_t rd_data_a_r;
  elem_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

/* rtl/flos_search.sv */
module flos_search
  import flos_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rightmost,
  input  srch_cmd_t  cmd,
  output addr_t      rd_addr,
  input  elem_t      rd_data,
  output srch_stat_t stat
);

  logic active_r, active_nxt;
  pos_t lo_r, lo_nxt;
  pos_t hi_r, hi_nxt;
  pos_t hit_r, hit_nxt;
  pos_t mid_r, mid_nxt;
  logic go;

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    hit_nxt = hit_r;
    if (cmd.start) begin
      lo_nxt  = '0;
      hi_nxt  = $signed({1'b0, cmd.len}) - pos_t'(1);
      hit_nxt = '1;
    end else if (active_r) begin
      if (rd_data == cmd.key) begin
        hit_nxt = mid_r;
        if (rightmost) begin
          lo_nxt = mid_r + pos_t'(1);
        end else begin
          hi_nxt = mid_r - pos_t'(1);
        end
      end else if (rd_data < cmd.key) begin
        lo_nxt = mid_r + pos_t'(1);
      end else begin
        hi_nxt = mid_r - pos_t'(1);
      end
    end
    go         = (lo_nxt <= hi_nxt);
    mid_nxt    = pos_t'(lo_nxt + hi_nxt) >>> 1;
    active_nxt = (cmd.start || active_r) && go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    hit_r <= hit_nxt;
    mid_r <= mid_nxt;
  end

  assign rd_addr   = mid_nxt[AW-1:0];
  assign stat.busy = active_r;
  assign stat.hit  = hit_r;

endmodule

/* rtl/first_last_occurrence_search.sv */
// Channel  Direction  Payload
// in_      input      tdata: elem_index, elem_value, search_key; tuser: opcode
// out_     output     tdata: first_pos, last_pos, found
// cfg_     input      data: array_length
//
// A write item is accepted and goes straight into the store. A query item is accepted,
// then probes the store once per search step and then loads the result register. The
// probe loop is bound by the registered read of the store. Reset is synchronous and
// clears control state only; store contents are undefined until written. A result held
// by a stalled output keeps the block in search.
module first_last_occurrence_search
  import flos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // elem_index, elem_value, search_key, zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // first_pos, last_pos, found, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  logic [9:0]         in_elem_index;
  logic signed [31:0] in_elem_value;
  logic signed [31:0] in_search_key;

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_r;
  len_t  len_sat;
  elem_t key_r;

  logic in_acc, start, wr_en, search_done, load_out;
  srch_cmd_t  cmd_l, cmd_r;
  srch_stat_t stat_l, stat_r;
  addr_t addr_l, addr_r;
  elem_t data_l, data_r;

  logic             out_valid_r;
  logic [POS_W-1:0] first_r, last_r;
  logic             found_r;

  assign in_elem_index = in_tdata[9:0];
  assign in_elem_value = in_tdata[41:10];
  assign in_search_key = in_tdata[73:42];

  assign in_acc  = in_tvalid && in_tready;
  assign start   = in_acc && (op_t'(in_tuser) == OP_QUERY);
  assign wr_en   = in_acc && (op_t'(in_tuser) == OP_WRITE) && (32'(in_elem_index) < DEPTH);
  assign len_sat = (32'(len_r) > DEPTH) ? LW'(DEPTH) : LW'(len_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_valid) begin
      len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= ELEM_WIDTH'(in_search_key);
    end
  end

  assign cmd_l.start = start;
  assign cmd_l.len   = len_sat;
  assign cmd_l.key   = key_r;
  assign cmd_r       = cmd_l;

  flos_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(in_elem_index)),
    .wr_data   (ELEM_WIDTH'(in_elem_value)),
    .rd_addr_a (addr_l),
    .rd_data_a (data_l),
    .rd_addr_b (addr_r),
    .rd_data_b (data_r)
  );

  flos_search u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .rightmost (1'b0),
    .cmd       (cmd_l),
    .rd_addr   (addr_l),
    .rd_data   (data_l),
    .stat      (stat_l)
  );

  flos_search u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .rightmost (1'b1),
    .cmd       (cmd_r),
    .rd_addr   (addr_r),
    .rd_data   (data_r),
    .stat      (stat_r)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    search_done = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_SEARCH: begin
        search_done = !stat_l.busy && !stat_r.busy;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    load_out = search_done && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      first_r <= stat_l.hit[POS_W-1:0];
      last_r  <= stat_r.hit[POS_W-1:0];
      found_r <= !stat_l.hit[PW-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, found_r, last_r, first_r};

endmodule

/* rtl/flos_checker.sv */
module flos_checker
  import flos_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result item changed.");

  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[22] |-> out_tdata[10:0] == 11'h7FF)
    else $error("Result without a match carries a first position.");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |->
      !out_tdata[10] && (!out_tdata[21] || out_tdata[21:11] == 11'h7FF))
    else $error("Match position is out of range.");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (op_t'(in_tuser) == OP_QUERY) |=> !in_tready)
    else $error("New item accepted while a query is in progress.");

endmodule

bind first_last_occurrence_search flos_checker u_flos_checker (.*);
